// File: hw/rtl/mp4_sample_to_chunk_walker_unit_assert.svh
// Assertion macros used by the checker of the sample-to-chunk walker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef MP4_SAMPLE_TO_CHUNK_WALKER_UNIT_ASSERT_SVH
`define MP4_SAMPLE_TO_CHUNK_WALKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MP4STC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sample-to-chunk walker check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MP4STC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sample-to-chunk walker check failed");

`endif

// File: hw/rtl/mp4stc_pkg.sv
// Shared types and command codes of the sample-to-chunk walker.
// No dependencies; every module of the block imports it.
`default_nettype none

package mp4stc_pkg;

	localparam logic [2:0] CMD_LOAD       = 3'd0;
	localparam logic [2:0] CMD_RESTART    = 3'd1;
	localparam logic [2:0] CMD_ADV_SAMPLE = 3'd2;
	localparam logic [2:0] CMD_ADV_CHUNK  = 3'd3;
	localparam logic [2:0] CMD_COUNT      = 3'd4;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [5:0]  entry_index;
		logic [31:0] entry_first_chunk;
		logic [31:0] entry_samples_per_chunk;
		logic [31:0] range_start;
		logic [31:0] range_end;
	} in_word_t;

	typedef struct packed {
		logic [31:0] chunk_now;
		logic [31:0] sample_in_chunk_now;
		logic        position_valid;
		logic [31:0] sample_total;
	} out_word_t;

	// One table entry as held by a ring cell.
	typedef struct packed {
		logic [31:0] first_chunk;
		logic [31:0] per_chunk;
	} entry_t;

	// Control from the sequencer to the range counter.
	typedef struct packed {
		logic clear;
		logic step;
	} cnt_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/mp4stc_cell.sv
// One cell of the entry ring: holds a single table entry.
// Depends on mp4stc_pkg for the entry type.
`default_nettype none

module mp4stc_cell (
	input  wire                 clk,
	input  wire                 shift,
	input  wire                 load,
	input  mp4stc_pkg::entry_t  load_entry,
	input  mp4stc_pkg::entry_t  next_entry,
	output mp4stc_pkg::entry_t  entry
);
	import mp4stc_pkg::*;

	entry_t entry_q;

	// Loads happen only while the ring rests; shifts only during a sweep.
	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_entry;
		end else if (shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// File: hw/rtl/mp4stc_count.sv
// Range counter that sits at the head of the entry ring.
// Depends on mp4stc_pkg; fed one entry per cycle by the top level.
`default_nettype none

module mp4stc_count #(
	parameter int IDX_W = 6,
	parameter int USE_W = 7
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  mp4stc_pkg::cnt_ctl_t  ctl,
	input  wire [IDX_W-1:0]       step_idx,
	input  wire [USE_W-1:0]       used_n,
	input  wire [31:0]            range_lo,
	input  wire [31:0]            range_hi,
	input  mp4stc_pkg::entry_t    cur_entry,
	input  wire [31:0]            next_start,
	output logic [31:0]           total
);
	import mp4stc_pkg::*;

	logic        done_q;
	logic        act_s1;
	logic [31:0] span_s1;
	logic [31:0] per_s1;
	logic        act_s2;
	logic [31:0] prod_s2;
	logic [31:0] total_q;

	logic [USE_W-1:0] idx_ext;
	logic        is_used;
	logic        is_last;
	logic [31:0] cover_end;
	logic [31:0] top_chunk;
	logic [31:0] bot_chunk;
	logic        go;

	always_comb begin
		idx_ext    = USE_W'(step_idx);
		is_used    = idx_ext < used_n;
		is_last    = (idx_ext + USE_W'(1)) == used_n;
		// The last entry runs to the end of the chunk number space.
		cover_end  = is_last ? 32'hFFFF_FFFF : (next_start - 32'd1);
		top_chunk  = (range_hi < cover_end) ? range_hi : cover_end;
		bot_chunk  = (range_lo > cur_entry.first_chunk) ? range_lo : cur_entry.first_chunk;
		go         = ctl.step && is_used && !done_q && !(range_hi < range_lo)
		             && (cover_end >= range_lo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			act_s1  <= 1'b0;
			act_s2  <= 1'b0;
			total_q <= 32'd0;
		end else begin
			act_s1 <= go;
			act_s2 <= act_s1;
			if (ctl.clear) begin
				done_q  <= 1'b0;
				total_q <= 32'd0;
			end else begin
				// Once an entry covers the top of the range, later entries add nothing.
				if (go && (cover_end >= range_hi)) begin
					done_q <= 1'b1;
				end
				if (act_s2) begin
					total_q <= total_q + prod_s2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		span_s1 <= top_chunk - bot_chunk + 32'd1;
		per_s1  <= cur_entry.per_chunk;
		prod_s2 <= 32'(span_s1 * per_s1);
	end

	assign total = total_q;

endmodule

`default_nettype wire

// File: hw/rtl/mp4_sample_to_chunk_walker_unit.sv
// Sample-to-chunk walker: each accepted command makes one full turn of the entry ring
// past the head, then passes ST_FLUSH_A, ST_FLUSH_B and ST_FINISH, where the result word
// is registered once any earlier word is taken; a new command is accepted only in idle.
// arst_n clears the walk position, entry_count and all handshake state at once;
// table entries are not cleared and hold whatever was last loaded.
`default_nettype none

module mp4_sample_to_chunk_walker_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire [6:0]              cfg_wdata,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  mp4stc_pkg::in_word_t   in_word,
	output logic                   out_valid,
	input  wire                    out_ready,
	output mp4stc_pkg::out_word_t  out_word
);
	import mp4stc_pkg::*;

	// The table lives in a ring of cells. Cell i holds entry i while the ring
	// rests. During a sweep each cell takes the entry of its upper neighbor, so
	// at sweep step k the head cell shows entry k and cell 1 shows entry k + 1.
	// After TABLE_DEPTH steps every entry is back at home.
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int USE_W = ($clog2(TABLE_DEPTH + 1) > 7) ? $clog2(TABLE_DEPTH + 1) : 7;
	localparam int NEXT1 = 1 % TABLE_DEPTH;
	localparam logic [USE_W-1:0] DEPTH_U = USE_W'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_K  = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FLUSH_A,
		ST_FLUSH_B,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [6:0]       entry_count_q;
	logic [IDX_W-1:0] ptr_q;
	logic [31:0]      chunk_q;
	logic [31:0]      sample_q;
	logic [IDX_W-1:0] sweep_k_q;

	logic [2:0]  cmd_q;
	logic [31:0] lo_q;
	logic [31:0] hi_q;

	// Entries around the walk pointer, picked off the ring as it turns.
	logic [31:0] cur_start_q;
	logic [31:0] cur_per_q;
	logic [31:0] nxt_start_q;
	logic [31:0] nxt_per_q;

	logic      out_valid_q;
	out_word_t out_q;

	entry_t cell_entry [TABLE_DEPTH];
	entry_t load_entry;

	logic       accept;
	logic       sweeping;
	cnt_ctl_t   cnt_ctl;
	logic [31:0] count_total;
	logic [USE_W-1:0] used_n;
	logic [IDX_W-1:0] cap_idx;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign sweeping  = (state_q == ST_SWEEP);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	assign load_entry.first_chunk = in_word.entry_first_chunk;
	assign load_entry.per_chunk   = in_word.entry_samples_per_chunk;

	// Counts above the table depth behave as the full table.
	assign used_n = (USE_W'(entry_count_q) > DEPTH_U) ? DEPTH_U : USE_W'(entry_count_q);

	// A restart needs entry 0; every other command looks at the pointed entry.
	assign cap_idx = (cmd_q == CMD_RESTART) ? '0 : ptr_q;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			localparam int UPPER = (gi + 1) % TABLE_DEPTH;
			logic cell_load;
			// A slot number outside the ring matches no cell, so the load is dropped.
			assign cell_load = accept && (in_word.cmd == CMD_LOAD)
			                   && (32'(in_word.entry_index) == gi);
			mp4stc_cell u_cell (
				.clk        (clk),
				.shift      (sweeping),
				.load       (cell_load),
				.load_entry (load_entry),
				.next_entry (cell_entry[UPPER]),
				.entry      (cell_entry[gi])
			);
		end
	endgenerate

	assign cnt_ctl.clear = accept;
	assign cnt_ctl.step  = sweeping && (cmd_q == CMD_COUNT);

	mp4stc_count #(
		.IDX_W (IDX_W),
		.USE_W (USE_W)
	) u_count (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cnt_ctl),
		.step_idx   (sweep_k_q),
		.used_n     (used_n),
		.range_lo   (lo_q),
		.range_hi   (hi_q),
		.cur_entry  (cell_entry[0]),
		.next_start (cell_entry[NEXT1].first_chunk),
		.total      (count_total)
	);

	// Walk update, evaluated once the sweep has gathered the entries it needs.
	logic [IDX_W-1:0] ptr_nx;
	logic [31:0]      chunk_nx;
	logic [31:0]      sample_nx;
	logic             moved;
	logic             valid_nx;
	logic             ptr_ok;
	logic             next_ok;
	logic             do_step;
	logic [31:0]      sample_inc;
	logic [31:0]      chunk_inc;

	always_comb begin
		ptr_nx     = ptr_q;
		chunk_nx   = chunk_q;
		sample_nx  = sample_q;
		moved      = 1'b0;
		do_step    = 1'b0;
		ptr_ok     = USE_W'(ptr_q) < used_n;
		next_ok    = (USE_W'(ptr_q) + USE_W'(1)) < used_n;
		sample_inc = sample_q + 32'd1;
		chunk_inc  = chunk_q + 32'd1;

		case (cmd_q)
			CMD_RESTART: begin
				ptr_nx    = '0;
				sample_nx = 32'd0;
				chunk_nx  = (used_n != '0) ? cur_start_q : 32'd0;
			end
			CMD_ADV_SAMPLE: begin
				// Running past the last sample of a chunk moves on to the next chunk.
				if (ptr_ok) begin
					if (sample_inc >= cur_per_q) begin
						do_step = 1'b1;
					end else begin
						sample_nx = sample_inc;
					end
				end
			end
			CMD_ADV_CHUNK: begin
				do_step = ptr_ok;
			end
			default: begin
			end
		endcase

		// The pointer moves at most one entry per chunk step.
		if (do_step) begin
			chunk_nx  = chunk_inc;
			sample_nx = 32'd0;
			if (next_ok && (chunk_inc >= nxt_start_q)) begin
				ptr_nx = ptr_q + IDX_W'(1);
				moved  = 1'b1;
			end
		end

		valid_nx = (USE_W'(ptr_nx) < used_n)
		           && (sample_nx < (moved ? nxt_per_q : cur_per_q));
	end

	// Sequencer, walk position and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= 7'd0;
			ptr_q         <= '0;
			chunk_q       <= 32'd0;
			sample_q      <= 32'd0;
			sweep_k_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				entry_count_q <= cfg_wdata;
			end
			// In the finish step a word taken now is replaced by the new one below.
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sweep_k_q <= '0;
						state_q   <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					sweep_k_q <= sweep_k_q + IDX_W'(1);
					if (sweep_k_q == LAST_K) begin
						state_q <= ST_FLUSH_A;
					end
				end
				ST_FLUSH_A: begin
					state_q <= ST_FLUSH_B;
				end
				ST_FLUSH_B: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// Hold here while an earlier result word still waits to be taken.
					if (!out_valid_q || out_ready) begin
						ptr_q       <= ptr_nx;
						chunk_q     <= chunk_nx;
						sample_q    <= sample_nx;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command fields and captured entries carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_word.cmd;
			lo_q  <= in_word.range_start;
			hi_q  <= in_word.range_end;
		end
		if (sweeping && (sweep_k_q == cap_idx)) begin
			cur_start_q <= cell_entry[0].first_chunk;
			cur_per_q   <= cell_entry[0].per_chunk;
			nxt_start_q <= cell_entry[NEXT1].first_chunk;
			nxt_per_q   <= cell_entry[NEXT1].per_chunk;
		end
		if ((state_q == ST_FINISH) && (!out_valid_q || out_ready)) begin
			out_q.chunk_now           <= chunk_nx;
			out_q.sample_in_chunk_now <= sample_nx;
			out_q.position_valid      <= valid_nx;
			out_q.sample_total        <= (cmd_q == CMD_COUNT) ? count_total : 32'd0;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mp4stc_checker.sv
// Port-level checks for the sample-to-chunk walker, bound to its top level.
// Depends on mp4stc_pkg and the assertion macro header.
`default_nettype none
`include "mp4_sample_to_chunk_walker_unit_assert.svh"

module mp4stc_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    in_valid,
	input wire                    in_ready,
	input wire                    out_valid,
	input wire                    out_ready,
	input mp4stc_pkg::out_word_t  out_word
);
	import mp4stc_pkg::*;

	// A word that waits keeps its value.
	`MP4STC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
	// Every command keeps the block busy for at least the flush and finish cycles.
	`MP4STC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
	// A new result word only appears as a command finishes.
	`MP4STC_ASSERT_IMP(a_result_from_finish, $rose(out_valid), $past(!in_ready))

endmodule

bind mp4_sample_to_chunk_walker_unit mp4stc_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

`default_nettype wire
